### rtl/core/nfeg_pkg.sv
// Package for the noise floor event gate: field widths, register codes,
// reset values, rule constants and the shared struct types. No dependencies.
package nfeg_pkg;

  // Field widths
  localparam int LVL_W   = 15;  // Q7.8 levels and floors
  localparam int RATE_W  = 16;  // Q0.16 tracking rate
  localparam int SUS_W   = 16;  // milliseconds
  localparam int SCORE_W = 7;   // whole-number scores
  localparam int ACT_W   = 3;   // modality count

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADAPT_RATE        = 3'd0,
    REG_ADAPT_MARGIN      = 3'd1,
    REG_FLOOR_MIN         = 3'd2,
    REG_FLOOR_MAX         = 3'd3,
    REG_MIN_SUSTAIN_MS    = 3'd4,
    REG_CONFIDENCE_CUTOFF = 3'd5,
    REG_LOUD_MARGIN       = 3'd6,
    REG_POP_PEAK_LEVEL    = 3'd7
  } cfg_idx_t;

  // Register reset values
  localparam logic [RATE_W-1:0]  RST_ADAPT_RATE        = 16'd655;
  localparam logic [LVL_W-1:0]   RST_ADAPT_MARGIN      = 15'd6400;
  localparam logic [LVL_W-1:0]   RST_FLOOR_MIN         = 15'd1280;
  localparam logic [LVL_W-1:0]   RST_FLOOR_MAX         = 15'd15360;
  localparam logic [SUS_W-1:0]   RST_MIN_SUSTAIN_MS    = 16'd250;
  localparam logic [SCORE_W-1:0] RST_CONFIDENCE_CUTOFF = 7'd90;
  localparam logic [LVL_W-1:0]   RST_LOUD_MARGIN       = 15'd11520;
  localparam logic [SCORE_W-1:0] RST_POP_PEAK_LEVEL    = 7'd70;

  // Floor reset values
  localparam logic [LVL_W-1:0] RST_MIC_FLOOR  = 15'd5120;  // 20.0
  localparam logic [LVL_W-1:0] RST_GAME_FLOOR = 15'd3840;  // 15.0

  // Fixed decision constants
  localparam logic [ACT_W-1:0]   MULTI_MODAL_MIN     = 3'd2;
  localparam logic [SCORE_W-1:0] POP_REACTION_LIMIT  = 7'd30;
  localparam logic [SCORE_W-1:0] BLIP_SPIKE_LEVEL    = 7'd50;
  localparam logic [LVL_W-1:0]   BLIP_MIC_LIMIT      = 15'd6400;  // 25.0
  localparam logic [LVL_W-1:0]   BLIP_GAME_MARGIN    = 15'd3840;  // 15.0
  localparam logic [SCORE_W-1:0] WEAK_REACTION_LIMIT = 7'd35;

  typedef struct packed {
    logic [RATE_W-1:0]  adapt_rate;
    logic [LVL_W-1:0]   adapt_margin;
    logic [LVL_W-1:0]   floor_min;
    logic [LVL_W-1:0]   floor_max;
    logic [SUS_W-1:0]   min_sustain_ms;
    logic [SCORE_W-1:0] confidence_cutoff;
    logic [LVL_W-1:0]   loud_margin;
    logic [SCORE_W-1:0] pop_peak_level;
  } cfg_t;

  typedef struct packed {
    logic [LVL_W-1:0]   mic_level;
    logic [LVL_W-1:0]   game_level;
    logic [SCORE_W-1:0] mic_peak;
    logic [SCORE_W-1:0] reaction_score;
    logic [SCORE_W-1:0] game_spike;
    logic [SCORE_W-1:0] confidence;
    logic               kill_feed;
    logic [SUS_W-1:0]   sustained_ms;
    logic [ACT_W-1:0]   active_modalities;
  } item_t;

endpackage

### rtl/core/nfeg_ifs.sv
// Valid/ready channel interfaces for snapshot items and result items.
// Depends on nfeg_pkg for field widths.
interface nfeg_in_if;
  import nfeg_pkg::*;

  logic               valid;
  logic               ready;
  logic [LVL_W-1:0]   mic_level;
  logic [LVL_W-1:0]   game_level;
  logic [SCORE_W-1:0] mic_peak;
  logic [SCORE_W-1:0] reaction_score;
  logic [SCORE_W-1:0] game_spike;
  logic [SCORE_W-1:0] confidence;
  logic               kill_feed;
  logic [SUS_W-1:0]   sustained_ms;
  logic [ACT_W-1:0]   active_modalities;

  modport source (
    output valid, mic_level, game_level, mic_peak, reaction_score, game_spike,
           confidence, kill_feed, sustained_ms, active_modalities,
    input  ready
  );
  modport sink (
    input  valid, mic_level, game_level, mic_peak, reaction_score, game_spike,
           confidence, kill_feed, sustained_ms, active_modalities,
    output ready
  );
endinterface

interface nfeg_out_if;
  import nfeg_pkg::*;

  logic             valid;
  logic             ready;
  logic             reject;
  logic [LVL_W-1:0] mic_floor_out;
  logic [LVL_W-1:0] game_floor_out;

  modport source (
    output valid, reject, mic_floor_out, game_floor_out,
    input  ready
  );
  modport sink (
    input  valid, reject, mic_floor_out, game_floor_out,
    output ready
  );
endinterface

### rtl/core/nfeg_cfg.sv
// Configuration register bank, written through a plain indexed write port.
// Depends on nfeg_pkg.
module nfeg_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [nfeg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nfeg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output nfeg_pkg::cfg_t                cfg
);
  import nfeg_pkg::*;

  cfg_t cfg_r;

  // Load reset values, then take one register per write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adapt_rate        <= RST_ADAPT_RATE;
      cfg_r.adapt_margin      <= RST_ADAPT_MARGIN;
      cfg_r.floor_min         <= RST_FLOOR_MIN;
      cfg_r.floor_max         <= RST_FLOOR_MAX;
      cfg_r.min_sustain_ms    <= RST_MIN_SUSTAIN_MS;
      cfg_r.confidence_cutoff <= RST_CONFIDENCE_CUTOFF;
      cfg_r.loud_margin       <= RST_LOUD_MARGIN;
      cfg_r.pop_peak_level    <= RST_POP_PEAK_LEVEL;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_ADAPT_RATE:        cfg_r.adapt_rate        <= cfg_wdata[RATE_W-1:0];
        REG_ADAPT_MARGIN:      cfg_r.adapt_margin      <= cfg_wdata[LVL_W-1:0];
        REG_FLOOR_MIN:         cfg_r.floor_min         <= cfg_wdata[LVL_W-1:0];
        REG_FLOOR_MAX:         cfg_r.floor_max         <= cfg_wdata[LVL_W-1:0];
        REG_MIN_SUSTAIN_MS:    cfg_r.min_sustain_ms    <= cfg_wdata[SUS_W-1:0];
        REG_CONFIDENCE_CUTOFF: cfg_r.confidence_cutoff <= cfg_wdata[SCORE_W-1:0];
        REG_LOUD_MARGIN:       cfg_r.loud_margin       <= cfg_wdata[LVL_W-1:0];
        REG_POP_PEAK_LEVEL:    cfg_r.pop_peak_level    <= cfg_wdata[SCORE_W-1:0];
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/nfeg_floor_upd.sv
// Next-value logic for one noise floor: gated exponential step, then clamp.
// Depends on nfeg_pkg.
module nfeg_floor_upd (
  input  logic [nfeg_pkg::LVL_W-1:0]  floor_cur,
  input  logic [nfeg_pkg::LVL_W-1:0]  level,
  input  logic [nfeg_pkg::RATE_W-1:0] adapt_rate,
  input  logic [nfeg_pkg::LVL_W-1:0]  adapt_margin,
  input  logic [nfeg_pkg::LVL_W-1:0]  floor_min,
  input  logic [nfeg_pkg::LVL_W-1:0]  floor_max,
  output logic [nfeg_pkg::LVL_W-1:0]  floor_nxt
);
  import nfeg_pkg::*;

  localparam int DIFF_W = LVL_W + 2;
  localparam int PROD_W = DIFF_W + RATE_W + 1;
  localparam int STEP_W = PROD_W - RATE_W;

  logic [LVL_W:0]             gate_sum;
  logic                       adapt;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [STEP_W-1:0]   step;
  logic signed [STEP_W-1:0]   moved;
  logic signed [STEP_W-1:0]   hi_lim;
  logic signed [STEP_W-1:0]   lo_lim;
  logic signed [STEP_W-1:0]   capped;
  logic signed [STEP_W-1:0]   clamped;

  // Adapt only while the level sits below floor plus margin
  assign gate_sum = {1'b0, floor_cur} + {1'b0, adapt_margin};
  assign adapt    = {1'b0, level} < gate_sum;

  // Step is (level - floor) * rate, shifted down with rounding toward minus infinity
  assign diff = $signed({2'b00, level}) - $signed({2'b00, floor_cur});
  assign prod = diff * $signed({1'b0, adapt_rate});
  assign step = prod[PROD_W-1:RATE_W];

  assign moved = $signed({{(STEP_W-LVL_W){1'b0}}, floor_cur}) +
                 (adapt ? step : STEP_W'(0));

  // Clamp to the maximum first, so the minimum wins on an inverted range
  assign hi_lim  = $signed({{(STEP_W-LVL_W){1'b0}}, floor_max});
  assign lo_lim  = $signed({{(STEP_W-LVL_W){1'b0}}, floor_min});
  assign capped  = (moved > hi_lim) ? hi_lim : moved;
  assign clamped = (capped < lo_lim) ? lo_lim : capped;

  assign floor_nxt = clamped[LVL_W-1:0];

endmodule

### rtl/core/nfeg_gate.sv
// Reject decision for one snapshot against the floors held before its update.
// Depends on nfeg_pkg.
module nfeg_gate (
  input  nfeg_pkg::item_t            item,
  input  logic [nfeg_pkg::LVL_W-1:0] mic_floor,
  input  logic [nfeg_pkg::LVL_W-1:0] game_floor,
  input  nfeg_pkg::cfg_t             cfg,
  output logic                       reject
);
  import nfeg_pkg::*;

  logic           protect;
  logic           sustained;
  logic [LVL_W:0] loud_sum;
  logic [LVL_W:0] blip_sum;
  logic           way_above;
  logic           pop;
  logic           blip;
  logic           faint;

  // Corroborated, kill-feed and high-confidence items always pass
  assign protect = (item.active_modalities >= MULTI_MODAL_MIN) || item.kill_feed ||
                   (item.confidence >= cfg.confidence_cutoff);

  assign sustained = item.sustained_ms >= cfg.min_sustain_ms;
  assign loud_sum  = {1'b0, mic_floor} + {1'b0, cfg.loud_margin};
  assign way_above = {1'b0, item.mic_level} > loud_sum;

  // Transient pop: loud peak, short, no reaction build-up
  assign pop = (item.mic_peak > cfg.pop_peak_level) && !sustained &&
               (item.reaction_score < POP_REACTION_LIMIT);

  // Lone game blip: game spike with quiet mic and game near its floor
  assign blip_sum = {1'b0, game_floor} + {1'b0, BLIP_GAME_MARGIN};
  assign blip = (item.game_spike > BLIP_SPIKE_LEVEL) &&
                (item.mic_level < BLIP_MIC_LIMIT) &&
                ({1'b0, item.game_level} < blip_sum);

  // Faint blip near the floor
  assign faint = !sustained && !way_above && (item.reaction_score < WEAK_REACTION_LIMIT);

  assign reject = !protect && (pop || blip || faint);

endmodule

### rtl/core/noise_floor_event_gate.sv
// Top level of the noise floor event gate: input register, floor state,
// decision and floor update, result register. Depends on nfeg_pkg, nfeg_ifs,
// nfeg_cfg, nfeg_floor_upd and nfeg_gate.
//
// Takes one metric snapshot per item and returns one result per item: the
// reject flag and both noise floors after the update. One item is accepted
// every clock cycle when the result side keeps up; a result is presented once
// its item has moved from the input register into the result register, which
// waits only while the result side holds off. The floors are updated when an
// item moves from the input register to the result register, so the next item
// sees them in the following cycle. The rate is set by that floor loop through
// the floor registers: one multiply, one subtract, two adds and three compares
// per floor. The user must write configuration only while no item is in
// flight; the block itself does not enforce it.
module noise_floor_event_gate (
  input  logic                          clk,
  input  logic                          rst_n,
  nfeg_in_if.sink                       in_ch,
  nfeg_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [nfeg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nfeg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import nfeg_pkg::*;

  cfg_t             cfg;
  item_t            in_item;
  item_t            s1_item_r;
  logic             s1_vld_r;
  logic             out_vld_r;
  logic             out_reject_r;
  logic [LVL_W-1:0] out_mic_r;
  logic [LVL_W-1:0] out_game_r;
  logic [LVL_W-1:0] mic_floor_r;
  logic [LVL_W-1:0] game_floor_r;
  logic [LVL_W-1:0] mic_floor_nxt;
  logic [LVL_W-1:0] game_floor_nxt;
  logic             reject_nxt;
  logic             out_free;
  logic             s1_go;
  logic             in_take;

  nfeg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Gather the input payload
  assign in_item = '{
    mic_level:         in_ch.mic_level,
    game_level:        in_ch.game_level,
    mic_peak:          in_ch.mic_peak,
    reaction_score:    in_ch.reaction_score,
    game_spike:        in_ch.game_spike,
    confidence:        in_ch.confidence,
    kill_feed:         in_ch.kill_feed,
    sustained_ms:      in_ch.sustained_ms,
    active_modalities: in_ch.active_modalities
  };

  // Handshake: advance the input register whenever the result slot frees up
  assign out_free    = !out_vld_r || out_ch.ready;
  assign s1_go       = s1_vld_r && out_free;
  assign in_ch.ready = !s1_vld_r || s1_go;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Decide on pre-update floors
  nfeg_gate u_gate (
    .item       (s1_item_r),
    .mic_floor  (mic_floor_r),
    .game_floor (game_floor_r),
    .cfg        (cfg),
    .reject     (reject_nxt)
  );

  nfeg_floor_upd u_mic_floor (
    .floor_cur    (mic_floor_r),
    .level        (s1_item_r.mic_level),
    .adapt_rate   (cfg.adapt_rate),
    .adapt_margin (cfg.adapt_margin),
    .floor_min    (cfg.floor_min),
    .floor_max    (cfg.floor_max),
    .floor_nxt    (mic_floor_nxt)
  );

  nfeg_floor_upd u_game_floor (
    .floor_cur    (game_floor_r),
    .level        (s1_item_r.game_level),
    .adapt_rate   (cfg.adapt_rate),
    .adapt_margin (cfg.adapt_margin),
    .floor_min    (cfg.floor_min),
    .floor_max    (cfg.floor_max),
    .floor_nxt    (game_floor_nxt)
  );

  // Control: valid flags and floor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      mic_floor_r  <= RST_MIC_FLOOR;
      game_floor_r <= RST_GAME_FLOOR;
    end else begin
      if (in_ch.ready) begin
        s1_vld_r <= in_ch.valid;
      end
      if (out_free) begin
        out_vld_r <= s1_vld_r;
      end
      if (s1_go) begin
        mic_floor_r  <= mic_floor_nxt;
        game_floor_r <= game_floor_nxt;
      end
    end
  end

  // Payload: hold the input item, load the result
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (s1_go) begin
      out_reject_r <= reject_nxt;
      out_mic_r    <= mic_floor_nxt;
      out_game_r   <= game_floor_nxt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.reject         = out_reject_r;
  assign out_ch.mic_floor_out  = out_mic_r;
  assign out_ch.game_floor_out = out_game_r;

endmodule

### tb/sv/noise_floor_event_gate_test.sv
// Self-checking testbench for noise_floor_event_gate: drives snapshot items,
// predicts reject flags and both noise floors, and checks every result item.
// Depends on nfeg_pkg, the nfeg_in_if/nfeg_out_if interfaces and the RTL top.
module noise_floor_event_gate_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nfeg_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 105;
  localparam int LONG_HOLD   = 300;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic             reject;
    logic [LVL_W-1:0] mic_floor;
    logic [LVL_W-1:0] game_floor;
  } gate_result_t;

  // Floor tracker and reject decision, with one expectation per accepted item
  class floor_gate_scoreboard;
    cfg_t             regs;
    logic [LVL_W-1:0] mic_floor;
    logic [LVL_W-1:0] game_floor;
    gate_result_t     expected_q[$];
    int               mismatches;
    int               checked;
    int               rejects;

    function new();
      regs.adapt_rate        = RST_ADAPT_RATE;
      regs.adapt_margin      = RST_ADAPT_MARGIN;
      regs.floor_min         = RST_FLOOR_MIN;
      regs.floor_max         = RST_FLOOR_MAX;
      regs.min_sustain_ms    = RST_MIN_SUSTAIN_MS;
      regs.confidence_cutoff = RST_CONFIDENCE_CUTOFF;
      regs.loud_margin       = RST_LOUD_MARGIN;
      regs.pop_peak_level    = RST_POP_PEAK_LEVEL;
      mic_floor  = RST_MIC_FLOOR;
      game_floor = RST_GAME_FLOOR;
      mismatches = 0;
      checked    = 0;
      rejects    = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ADAPT_RATE:        regs.adapt_rate        = data;
        REG_ADAPT_MARGIN:      regs.adapt_margin      = data[LVL_W-1:0];
        REG_FLOOR_MIN:         regs.floor_min         = data[LVL_W-1:0];
        REG_FLOOR_MAX:         regs.floor_max         = data[LVL_W-1:0];
        REG_MIN_SUSTAIN_MS:    regs.min_sustain_ms    = data;
        REG_CONFIDENCE_CUTOFF: regs.confidence_cutoff = data[SCORE_W-1:0];
        REG_LOUD_MARGIN:       regs.loud_margin       = data[LVL_W-1:0];
        REG_POP_PEAK_LEVEL:    regs.pop_peak_level    = data[SCORE_W-1:0];
        default: ;
      endcase
    endfunction

    // Gated exponential average, then clamp: max first, so floor_min wins
    function logic [LVL_W-1:0] track(logic [LVL_W-1:0] fl, logic [LVL_W-1:0] lvl);
      longint v;
      longint prod;
      v = longint'(fl);
      if (longint'(lvl) < longint'(fl) + longint'(regs.adapt_margin)) begin
        prod = (longint'(lvl) - longint'(fl)) * longint'(regs.adapt_rate);
        v = v + (prod >>> 16);
      end
      if (v > longint'(regs.floor_max)) v = longint'(regs.floor_max);
      if (v < longint'(regs.floor_min)) v = longint'(regs.floor_min);
      return v[LVL_W-1:0];
    endfunction

    // Reject decision against the floors held before this item
    function bit judge(item_t it);
      bit sustained;
      bit loud;
      bit pop;
      bit blip;
      if (it.active_modalities >= MULTI_MODAL_MIN || it.kill_feed ||
          it.confidence >= regs.confidence_cutoff) return 1'b0;
      sustained = it.sustained_ms >= regs.min_sustain_ms;
      loud = int'(it.mic_level) > int'(mic_floor) + int'(regs.loud_margin);
      pop  = it.mic_peak > regs.pop_peak_level && !sustained &&
             it.reaction_score < POP_REACTION_LIMIT;
      blip = it.game_spike > BLIP_SPIKE_LEVEL && it.mic_level < BLIP_MIC_LIMIT &&
             int'(it.game_level) < int'(game_floor) + int'(BLIP_GAME_MARGIN);
      if (pop || blip) return 1'b1;
      return !sustained && !loud && it.reaction_score < WEAK_REACTION_LIMIT;
    endfunction

    function void note_input(item_t it);
      gate_result_t want;
      want.reject = judge(it);
      mic_floor  = track(mic_floor, it.mic_level);
      game_floor = track(game_floor, it.game_level);
      want.mic_floor  = mic_floor;
      want.game_floor = game_floor;
      expected_q.push_back(want);
    endfunction

    function void check_result(gate_result_t got);
      gate_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] unexpected result: reject=%0d mic=%0d game=%0d",
                   $time, got.reject, got.mic_floor, got.game_floor);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.reject) rejects++;
      if (got.reject !== want.reject || got.mic_floor !== want.mic_floor ||
          got.game_floor !== want.game_floor) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] mismatch reject/mic/game: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                   $time, want.reject, want.mic_floor, want.game_floor,
                   got.reject, got.mic_floor, got.game_floor);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nfeg_in_if  in_ch();
  nfeg_out_if out_ch();

  noise_floor_event_gate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  floor_gate_scoreboard sb = new();
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  int hold_cycles_req = 0;
  int cycles = 0;
  int settings_used = 1;

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // Check results first, then note the item accepted at the same edge
  always @(posedge clk) begin
    gate_result_t got;
    item_t        it;
    if (out_ch.valid && out_ch.ready) begin
      got.reject     = out_ch.reject;
      got.mic_floor  = out_ch.mic_floor_out;
      got.game_floor = out_ch.game_floor_out;
      sb.check_result(got);
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      it.mic_level         = in_ch.mic_level;
      it.game_level        = in_ch.game_level;
      it.mic_peak          = in_ch.mic_peak;
      it.reaction_score    = in_ch.reaction_score;
      it.game_spike        = in_ch.game_spike;
      it.confidence        = in_ch.confidence;
      it.kill_feed         = in_ch.kill_feed;
      it.sustained_ms      = in_ch.sustained_ms;
      it.active_modalities = in_ch.active_modalities;
      sb.note_input(it);
    end
  end

  // Result side: long hold on request, random stall bursts, ready stretches
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_cycles_req > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles_req) @(posedge clk);
        hold_cycles_req = 0;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Offer one item, hold it until accepted, then maybe idle for a burst
  task automatic send_item(input item_t it);
    in_ch.mic_level         <= it.mic_level;
    in_ch.game_level        <= it.game_level;
    in_ch.mic_peak          <= it.mic_peak;
    in_ch.reaction_score    <= it.reaction_score;
    in_ch.game_spike        <= it.game_spike;
    in_ch.confidence        <= it.confidence;
    in_ch.kill_feed         <= it.kill_feed;
    in_ch.sustained_ms      <= it.sustained_ms;
    in_ch.active_modalities <= it.active_modalities;
    in_ch.valid             <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result has come
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Write all eight registers for one setting
  task automatic apply_setting(input int phase);
    logic [CFG_DATA_W-1:0] vals [8];
    cfg_idx_t r;
    int lo;
    case (phase)
      1: begin
        // Fastest tracking, widest gate, everything counts as sustained
        vals[REG_ADAPT_RATE]        = 16'hFFFF;
        vals[REG_ADAPT_MARGIN]      = 16'hFFFF;
        vals[REG_FLOOR_MIN]         = '0;
        vals[REG_FLOOR_MAX]         = 16'hFFFF;
        vals[REG_MIN_SUSTAIN_MS]    = '0;
        vals[REG_CONFIDENCE_CUTOFF] = 16'hFFFF;
        vals[REG_LOUD_MARGIN]       = '0;
        vals[REG_POP_PEAK_LEVEL]    = '0;
      end
      2: begin
        // Frozen tracking and an inverted clamp
        vals[REG_ADAPT_RATE]        = '0;
        vals[REG_ADAPT_MARGIN]      = '0;
        vals[REG_FLOOR_MIN]         = 16'd25600;
        vals[REG_FLOOR_MAX]         = '0;
        vals[REG_MIN_SUSTAIN_MS]    = 16'hFFFF;
        vals[REG_CONFIDENCE_CUTOFF] = '0;
        vals[REG_LOUD_MARGIN]       = 16'h7FFF;
        vals[REG_POP_PEAK_LEVEL]    = 16'd127;
      end
      5: begin
        // Floors pinned at the top of the field, tightest cutoffs in range
        vals[REG_ADAPT_RATE]        = 16'd1;
        vals[REG_ADAPT_MARGIN]      = 16'd25600;
        vals[REG_FLOOR_MIN]         = 16'h7FFF;
        vals[REG_FLOOR_MAX]         = 16'h7FFF;
        vals[REG_MIN_SUSTAIN_MS]    = 16'hFFFF;
        vals[REG_CONFIDENCE_CUTOFF] = 16'd100;
        vals[REG_LOUD_MARGIN]       = 16'd25600;
        vals[REG_POP_PEAK_LEVEL]    = 16'd100;
      end
      6: begin
        vals[REG_ADAPT_RATE]        = RST_ADAPT_RATE;
        vals[REG_ADAPT_MARGIN]      = RST_ADAPT_MARGIN;
        vals[REG_FLOOR_MIN]         = RST_FLOOR_MIN;
        vals[REG_FLOOR_MAX]         = RST_FLOOR_MAX;
        vals[REG_MIN_SUSTAIN_MS]    = RST_MIN_SUSTAIN_MS;
        vals[REG_CONFIDENCE_CUTOFF] = RST_CONFIDENCE_CUTOFF;
        vals[REG_LOUD_MARGIN]       = RST_LOUD_MARGIN;
        vals[REG_POP_PEAK_LEVEL]    = RST_POP_PEAK_LEVEL;
      end
      default: begin
        lo = $urandom_range(0, 8000);
        vals[REG_ADAPT_RATE]        = ($urandom_range(0, 4) == 0) ?
                                      CFG_DATA_W'($urandom_range(0, 65535)) :
                                      CFG_DATA_W'($urandom_range(0, 8000));
        vals[REG_ADAPT_MARGIN]      = CFG_DATA_W'($urandom_range(0, 25600));
        vals[REG_FLOOR_MIN]         = CFG_DATA_W'(lo);
        vals[REG_FLOOR_MAX]         = CFG_DATA_W'($urandom_range(lo, 25600));
        vals[REG_MIN_SUSTAIN_MS]    = CFG_DATA_W'($urandom_range(0, 1000));
        vals[REG_CONFIDENCE_CUTOFF] = CFG_DATA_W'($urandom_range(50, 100));
        vals[REG_LOUD_MARGIN]       = CFG_DATA_W'($urandom_range(0, 25600));
        vals[REG_POP_PEAK_LEVEL]    = CFG_DATA_W'($urandom_range(0, 100));
      end
    endcase
    r = REG_ADAPT_RATE;
    repeat (r.num()) begin
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= vals[r];
      sb.write_reg(r, vals[r]);
      @(posedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic item_t snap(int mic, int game, int peak, int react, int spike,
                                 int conf, int kill, int sus, int act);
    item_t it;
    it.mic_level         = mic[LVL_W-1:0];
    it.game_level        = game[LVL_W-1:0];
    it.mic_peak          = peak[SCORE_W-1:0];
    it.reaction_score    = react[SCORE_W-1:0];
    it.game_spike        = spike[SCORE_W-1:0];
    it.confidence        = conf[SCORE_W-1:0];
    it.kill_feed         = kill[0];
    it.sustained_ms      = sus[SUS_W-1:0];
    it.active_modalities = act[ACT_W-1:0];
    return it;
  endfunction

  // Level near the floor, near the adaptation edge, in range or full width
  function automatic int pick_level(logic [LVL_W-1:0] fl);
    int k;
    int v;
    k = $urandom_range(0, 9);
    if (k < 4) v = int'(fl) + int'($urandom_range(0, 8000)) - 4000;
    else if (k == 4) v = int'(fl) + int'(sb.regs.adapt_margin) + int'($urandom_range(0, 6)) - 3;
    else if (k < 8) v = $urandom_range(0, 25600);
    else v = $urandom_range(0, 32767);
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  function automatic int pick_score();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return $urandom_range(0, 100);
    if (k < 8) return $urandom_range(25, 75);
    return $urandom_range(0, 127);
  endfunction

  function automatic item_t random_snapshot();
    int k;
    int sus;
    int conf;
    k = $urandom_range(0, 9);
    if (k < 4) sus = int'(sb.regs.min_sustain_ms) + int'($urandom_range(0, 6)) - 3;
    else if (k < 7) sus = $urandom_range(0, 65535);
    else if (k == 7) sus = 0;
    else if (k == 8) sus = 65535;
    else sus = $urandom_range(0, 1000);
    if (sus < 0) sus = 0;
    if (sus > 65535) sus = 65535;
    if ($urandom_range(0, 9) < 7) conf = $urandom_range(0, sb.regs.confidence_cutoff);
    else conf = $urandom_range(0, 127);
    return snap(pick_level(sb.mic_floor), pick_level(sb.game_floor), pick_score(),
                pick_score(), pick_score(), conf, ($urandom_range(0, 4) == 0),
                sus, ($urandom_range(0, 9) < 6) ? $urandom_range(0, 1) :
                $urandom_range(0, 7));
  endfunction

  initial begin
    item_t directed_q[$];
    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_index               <= REG_ADAPT_RATE;
    cfg_wdata               <= '0;
    in_ch.valid             <= 1'b0;
    in_ch.mic_level         <= '0;
    in_ch.game_level        <= '0;
    in_ch.mic_peak          <= '0;
    in_ch.reaction_score    <= '0;
    in_ch.game_spike        <= '0;
    in_ch.confidence        <= '0;
    in_ch.kill_feed         <= 1'b0;
    in_ch.sustained_ms      <= '0;
    in_ch.active_modalities <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes, every never-reject path and each rule at its boundary
    directed_q.push_back(snap(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(snap(32767, 32767, 127, 127, 127, 127, 1, 65535, 7));
    directed_q.push_back(snap(100, 100, 0, 0, 0, 0, 0, 0, 2));
    directed_q.push_back(snap(100, 100, 0, 0, 0, 0, 1, 0, 1));
    directed_q.push_back(snap(100, 100, 0, 0, 0, 90, 0, 0, 0));
    directed_q.push_back(snap(100, 100, 0, 0, 0, 89, 0, 0, 0));
    directed_q.push_back(snap(20000, 3000, 71, 29, 0, 10, 0, 249, 1));
    directed_q.push_back(snap(20000, 3000, 70, 29, 0, 10, 0, 249, 1));
    directed_q.push_back(snap(20000, 3000, 71, 30, 0, 10, 0, 249, 1));
    directed_q.push_back(snap(20000, 3000, 71, 29, 0, 10, 0, 250, 1));
    directed_q.push_back(snap(6399, 3000, 0, 60, 51, 10, 0, 1000, 0));
    directed_q.push_back(snap(6400, 3000, 0, 60, 51, 10, 0, 1000, 0));
    directed_q.push_back(snap(6399, 3000, 0, 60, 50, 10, 0, 1000, 0));
    directed_q.push_back(snap(6399, 9000, 0, 60, 51, 10, 0, 1000, 0));
    directed_q.push_back(snap(5000, 4000, 0, 34, 0, 10, 0, 100, 0));
    directed_q.push_back(snap(5000, 4000, 0, 35, 0, 10, 0, 100, 0));
    directed_q.push_back(snap(25600, 25600, 100, 100, 100, 100, 0, 65535, 1));
    directed_q.push_back(snap(0, 25600, 0, 0, 0, 0, 0, 0, 0));
    foreach (directed_q[i]) send_item(directed_q[i]);
    repeat (90) send_item(random_snapshot());

    for (int phase = 1; phase <= 6; phase++) begin
      drain_results();
      // Final setting runs with both sides at full rate
      if (phase == 6) begin
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
      end
      apply_setting(phase);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == 20) begin
          // Back up the block behind a long output stall
          hold_cycles_req = LONG_HOLD;
          sender_idles = 1'b0;
          repeat (40) send_item(random_snapshot());
          sender_idles = 1'b1;
        end
        if (phase == 4 && n == 50) drain_results();
        send_item(random_snapshot());
      end
    end

    drain_results();
    repeat (6) @(posedge clk);
    $display("checked %0d snapshot results (%0d rejects) across %0d register settings",
             sb.checked, sb.rejects, settings_used);
    $display("mismatches: %0d, results still outstanding: %0d", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/nfeg_pkg.sv
rtl/core/nfeg_ifs.sv
rtl/core/nfeg_cfg.sv
rtl/core/nfeg_floor_upd.sv
rtl/core/nfeg_gate.sv
rtl/core/noise_floor_event_gate.sv
tb/sv/noise_floor_event_gate_test.sv
